@@ rtl/ssc_pkg.sv @@
// Shared types and constants for the shell subscript close finder.
// Holds the scan mode enum, the input item and result structs and the byte codes.
// No dependencies; imported by every module of the block.
package ssc_pkg;

  // Byte codes the scanner reacts to
  localparam logic [7:0] CH_OPEN_SQ  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE_SQ = 8'h5D;  // ']'
  localparam logic [7:0] CH_OPEN_BR  = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE_BR = 8'h7D;  // '}'
  localparam logic [7:0] CH_OPEN_PA  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE_PA = 8'h29;  // ')'
  localparam logic [7:0] CH_DOLLAR   = 8'h24;  // '$'
  localparam logic [7:0] CH_SQUOTE   = 8'h27;  // single quote
  localparam logic [7:0] CH_DQUOTE   = 8'h22;  // double quote
  localparam logic [7:0] CH_BSLASH   = 8'h5C;  // backslash

  localparam int unsigned PosW = 16;

  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_MAIN      = 4'd1,
    MODE_MAIN_ESC  = 4'd2,
    MODE_DOLLAR    = 4'd3,
    MODE_CONSTRUCT = 4'd4,
    MODE_SQ        = 4'd5,
    MODE_DQ        = 4'd6,
    MODE_DQ_ESC    = 4'd7
  } scan_mode_e;

  // One byte of the stream with its markers
  typedef struct packed {
    logic       last_byte;
    logic       begin_scan;
    logic [7:0] ch;
  } item_t;

  // One scan result
  typedef struct packed {
    logic            depth_overflow;
    logic [PosW-1:0] offset;
    logic            found;
  } result_t;

endpackage

@@ rtl/shell_subscript_close_finder_core.sv @@
// Top level of the shell subscript close finder.
// Instantiates ssc_in_stage and ssc_scan and holds the result register; uses ssc_pkg.
//
// Usage: bytes of a string arrive one per request on the s_axis channel. tuser marks
// the byte at the open position (expected '['), tlast marks the final byte. For each
// scan one result leaves on m_axis: tuser[0] found, tuser[1] depth counter saturated,
// tdata the offset of the matching ']' from the '[' (0 when not found). Bytes seen
// while no scan runs are dropped. A new open marker aborts a scan in progress.
// Throughput: one byte per cycle unless m_axis stalls; the whole mode update is one
// combinational step between the input register and the result register.
// Path: an accepted byte waits in the input register until it is stepped; its result
// is then held in the result register and presented on m_axis.
// Stall: while a result waits on m_axis, the input register still takes one byte;
// further bytes wait until m_axis_tready frees the result register.
// Reset: rst_ni low clears the valid flags of both registers and puts the scanner idle, no scan open.
module shell_subscript_close_finder_core #(
  parameter int unsigned MAX_LEN   = 65536,
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] begin_scan
  input  logic        s_axis_tlast,   // last_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] offset
  output logic [1:0]  m_axis_tuser    // [0] found, [1] depth_overflow
);
  import ssc_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign in_item.ch         = s_axis_tdata;
  assign in_item.begin_scan = s_axis_tuser;
  assign in_item.last_byte  = s_axis_tlast;

  // The step fires whenever the result register can take whatever it makes
  assign advance = !out_valid_q || m_axis_tready;

  ssc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (stage_valid),
    .item_o       (stage_item)
  );

  ssc_scan #(
    .MAX_LEN   (MAX_LEN),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .advance_i    (advance),
    .item_i       (stage_item),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = stage_valid && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_valid && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.offset;
  assign m_axis_tuser[0] = out_q.found;
  assign m_axis_tuser[1] = out_q.depth_overflow;

endmodule

@@ rtl/ssc_in_stage.sv @@
// Input register of the close finder: holds one request until the scan step takes it.
// Depends on ssc_pkg for the item struct.
module ssc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ssc_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          item_valid_o,
  output ssc_pkg::item_t item_o
);
  import ssc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Free when empty or when the held request moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/ssc_scan.sv @@
// Scan state and combinational step logic of the close finder.
// Tracks mode, depths and position; flags a result for the byte being stepped.
// Depends on ssc_pkg.
module ssc_scan #(
  parameter int unsigned MAX_LEN   = 65536,
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic             advance_i,
  input  ssc_pkg::item_t   item_i,
  output logic             res_valid_o,
  output ssc_pkg::result_t res_o
);
  import ssc_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned LenCap = (MAX_LEN < 65536) ? MAX_LEN : 65536;
  localparam logic [PosW-1:0]   LastPos  = PosW'(LenCap - 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_DEPTH);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);
  localparam logic              CapTiny  = (LenCap <= 1);

  scan_mode_e        mode_q, mode_d;
  logic [DepthW-1:0] bdepth_q, bdepth_d;
  logic [DepthW-1:0] cdepth_q, cdepth_d;
  logic              paren_q, paren_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              ovf_q, ovf_d;

  logic [PosW-1:0]   pos_inc;
  logic [7:0]        opener, closer;
  logic              main_en;
  logic              hit;
  logic              dead;
  logic              step;

  assign step    = item_valid_i && advance_i;
  assign pos_inc = pos_q + PosW'(1);
  assign opener  = paren_q ? CH_OPEN_PA : CH_OPEN_BR;
  assign closer  = paren_q ? CH_CLOSE_PA : CH_CLOSE_BR;

  // Next state and result for one byte
  always_comb begin
    mode_d      = mode_q;
    bdepth_d    = bdepth_q;
    cdepth_d    = cdepth_q;
    paren_d     = paren_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    main_en     = 1'b0;
    hit         = 1'b0;
    dead        = 1'b0;

    if (item_i.begin_scan) begin
      // (re)start: clear everything, check the opening byte
      mode_d   = MODE_IDLE;
      bdepth_d = '0;
      cdepth_d = '0;
      paren_d  = 1'b0;
      pos_d    = '0;
      ovf_d    = 1'b0;
      if (item_i.ch != CH_OPEN_SQ || item_i.last_byte || CapTiny) begin
        res_valid_o = 1'b1;
      end else begin
        mode_d   = MODE_MAIN;
        bdepth_d = DepthOne;
      end
    end else if (mode_q != MODE_IDLE) begin
      pos_d = pos_inc;
      unique case (mode_q)
        MODE_MAIN: begin
          main_en = 1'b1;
        end
        MODE_MAIN_ESC: begin
          mode_d = MODE_MAIN;
        end
        MODE_DOLLAR: begin
          if (item_i.ch == CH_OPEN_BR || item_i.ch == CH_OPEN_PA) begin
            paren_d  = (item_i.ch == CH_OPEN_PA);
            cdepth_d = DepthOne;
            mode_d   = MODE_CONSTRUCT;
          end else begin
            main_en = 1'b1;
          end
        end
        MODE_CONSTRUCT: begin
          priority if (item_i.ch == CH_SQUOTE) begin
            mode_d = MODE_SQ;
          end else if (item_i.ch == CH_DQUOTE) begin
            mode_d = MODE_DQ;
          end else if (item_i.ch == opener) begin
            if (cdepth_q >= DepthMax) begin
              cdepth_d = DepthMax;
              ovf_d    = 1'b1;
            end else begin
              cdepth_d = cdepth_q + DepthOne;
            end
          end else if (item_i.ch == closer) begin
            if (cdepth_q <= DepthOne) begin
              cdepth_d = '0;
              mode_d   = MODE_MAIN;
            end else begin
              cdepth_d = cdepth_q - DepthOne;
            end
          end else begin
            mode_d = MODE_CONSTRUCT;
          end
        end
        MODE_SQ: begin
          if (item_i.ch == CH_SQUOTE) begin
            mode_d = (cdepth_q != '0) ? MODE_CONSTRUCT : MODE_MAIN;
          end
        end
        MODE_DQ: begin
          priority if (item_i.ch == CH_DQUOTE) begin
            mode_d = (cdepth_q != '0) ? MODE_CONSTRUCT : MODE_MAIN;
          end else if (item_i.ch == CH_BSLASH) begin
            mode_d = MODE_DQ_ESC;
          end else begin
            mode_d = MODE_DQ;
          end
        end
        MODE_DQ_ESC: begin
          mode_d = MODE_DQ;
        end
        default: begin
          mode_d = MODE_IDLE;
          dead   = 1'b1;
        end
      endcase

      // Main subscript context, shared by plain text and a '$' without opener
      if (main_en) begin
        mode_d = MODE_MAIN;
        priority if (item_i.ch == CH_BSLASH) begin
          mode_d = MODE_MAIN_ESC;
        end else if (item_i.ch == CH_SQUOTE) begin
          mode_d = MODE_SQ;
        end else if (item_i.ch == CH_DQUOTE) begin
          mode_d = MODE_DQ;
        end else if (item_i.ch == CH_DOLLAR) begin
          mode_d = MODE_DOLLAR;
        end else if (item_i.ch == CH_OPEN_SQ) begin
          if (bdepth_q >= DepthMax) begin
            bdepth_d = DepthMax;
            ovf_d    = 1'b1;
          end else begin
            bdepth_d = bdepth_q + DepthOne;
          end
        end else if (item_i.ch == CH_CLOSE_SQ) begin
          if (bdepth_q <= DepthOne) begin
            bdepth_d = '0;
            hit      = 1'b1;
          end else begin
            bdepth_d = bdepth_q - DepthOne;
          end
        end else begin
          mode_d = MODE_MAIN;
        end
      end

      // Match, end of string or length limit closes the scan
      if (!dead) begin
        if (hit) begin
          res_valid_o          = 1'b1;
          res_o.found          = 1'b1;
          res_o.offset         = pos_inc;
          res_o.depth_overflow = ovf_d;
          mode_d               = MODE_IDLE;
        end else if (item_i.last_byte || pos_inc >= LastPos) begin
          res_valid_o          = 1'b1;
          res_o.depth_overflow = ovf_d;
          mode_d               = MODE_IDLE;
        end
      end
    end
  end

  // State registers, updated when a byte is stepped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      bdepth_q <= '0;
      cdepth_q <= '0;
      paren_q  <= 1'b0;
      pos_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (step) begin
      mode_q   <= mode_d;
      bdepth_q <= bdepth_d;
      cdepth_q <= cdepth_d;
      paren_q  <= paren_d;
      pos_q    <= pos_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule
